>>> rtl/core/dxt3_pkg.sv
// Shared types, constants and helper functions for the DXT3 block decoder.
// Used by every module in rtl/core; it depends on nothing else.
package dxt3_pkg;

    // Largest image dimension honoured; larger register values are clamped.
    localparam int unsigned MaxDimension = 16384;
    localparam int unsigned DimWidth     = 15;
    localparam int unsigned CoordWidth   = 14;
    localparam int unsigned PosWidth     = 12;
    localparam int unsigned PixelCount   = 16;
    localparam int unsigned QueueDepth   = 2;

    // Configuration register indexes.
    localparam logic CfgImageWidth  = 1'b0;
    localparam logic CfgImageHeight = 1'b1;

    // One decoded block waiting for the pixel stage.
    typedef struct packed {
        logic [CoordWidth-1:0] base_x;
        logic [CoordWidth-1:0] base_y;
        logic [15:0]           mask;
        logic [63:0]           alpha_bits;
        logic [31:0]           index_bits;
        logic [3:0][7:0]       pal_red;
        logic [3:0][7:0]       pal_green;
        logic [3:0][7:0]       pal_blue;
    } block_entry_t;

    // Fill status of the block queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Floor of s / 3 for s below 768, by multiplication with 683 / 2048.
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [19:0] prod;
        prod = s * 10'd683;
        return prod[18:11];
    endfunction

    // Interpolated palette entry (2a + b + 1) / 3.
    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b);
        logic [9:0] sum;
        sum = {1'b0, a, 1'b0} + {2'b00, b} + 10'd1;
        return div3(sum);
    endfunction

endpackage

>>> rtl/core/dxt3_if.sv
// Handshake interfaces for compressed blocks in and decoded pixels out.
// Depends on nothing; sits after dxt3_pkg in the compile order.
interface dxt3_block_if;
    logic        valid;
    logic        ready;
    logic [63:0] alpha_bits;
    logic [15:0] endpoint_first;
    logic [15:0] endpoint_second;
    logic [31:0] index_bits;

    modport source (output valid, alpha_bits, endpoint_first, endpoint_second,
                    index_bits, input ready);
    modport sink (input valid, alpha_bits, endpoint_first, endpoint_second,
                  index_bits, output ready);
endinterface

interface dxt3_pixel_if;
    logic        valid;
    logic        ready;
    logic [13:0] pixel_x;
    logic [13:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        block_done;

    modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha,
                    block_done, input ready);
    modport sink (input valid, pixel_x, pixel_y, red, green, blue, alpha,
                  block_done, output ready);
endinterface

>>> rtl/core/dxt3_block_decoder.sv
// DXT3 block decoder top level: configuration registers, front end, queue, pixel stage.
// Blocks pass a queue slot and the current-block register, then the output register.
// Throughput: one pixel word per cycle while the output is not stalled; a block gives
// one word per pixel inside the image, sixteen for a full block, and the two-entry queue
// lets new blocks be taken while earlier ones are still being emitted.
// Reset: rst_n clears the block position, the queue and the output; size registers read 4.
module dxt3_block_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    dxt3_block_if.sink                    blocks,
    dxt3_pixel_if.source                  pixels,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [dxt3_pkg::DimWidth-1:0] cfg_data
);

    logic [dxt3_pkg::DimWidth-1:0] width_reg, height_reg;
    logic                    push, pop;
    dxt3_pkg::block_entry_t  push_entry, head;
    dxt3_pkg::queue_status_t q_status;

    // Image size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dxt3_pkg::DimWidth'(4);
            height_reg <= dxt3_pkg::DimWidth'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dxt3_pkg::CfgImageWidth:  width_reg  <= cfg_data;
                dxt3_pkg::CfgImageHeight: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    dxt3_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .blocks       (blocks),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_status     (q_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    dxt3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    dxt3_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .pixels   (pixels)
    );

endmodule

>>> rtl/core/dxt3_front.sv
// Front end: accepts blocks, builds the palette, the in-image pixel mask and
// the block position. Depends on dxt3_pkg and dxt3_if.
module dxt3_front (
    input  logic                       clk,
    input  logic                       rst_n,
    dxt3_block_if.sink                 blocks,
    input  logic [dxt3_pkg::DimWidth-1:0] image_width,
    input  logic [dxt3_pkg::DimWidth-1:0] image_height,
    input  dxt3_pkg::queue_status_t    q_status,
    output logic                       push,
    output dxt3_pkg::block_entry_t     push_entry
);

    logic [dxt3_pkg::PosWidth-1:0] col_reg, col_next;
    logic [dxt3_pkg::PosWidth-1:0] row_reg, row_next;
    logic [dxt3_pkg::DimWidth-1:0] eff_w, eff_h;
    logic [dxt3_pkg::PosWidth:0]   col_inc, row_inc;
    logic [dxt3_pkg::CoordWidth-1:0] base_x, base_y;
    logic [7:0] r0, g0, b0, r1, g1, b1;
    logic [15:0] mask;
    logic        accept;

    assign blocks.ready = !q_status.full;
    assign accept       = blocks.valid && blocks.ready;

    // Clamp the image size to the supported maximum.
    always_comb
    begin
        eff_w = (image_width > dxt3_pkg::DimWidth'(dxt3_pkg::MaxDimension))
              ? dxt3_pkg::DimWidth'(dxt3_pkg::MaxDimension) : image_width;
        eff_h = (image_height > dxt3_pkg::DimWidth'(dxt3_pkg::MaxDimension))
              ? dxt3_pkg::DimWidth'(dxt3_pkg::MaxDimension) : image_height;
    end

    assign base_x = {col_reg, 2'b00};
    assign base_y = {row_reg, 2'b00};

    // A pixel survives when both its coordinates fall inside the image.
    always_comb
    begin
        for (int i = 0; i < dxt3_pkg::PixelCount; i++)
        begin
            mask[i] = ({1'b0, base_x} + dxt3_pkg::DimWidth'(i % 4) < eff_w) &&
                      ({1'b0, base_y} + dxt3_pkg::DimWidth'(i / 4) < eff_h);
        end
    end

    // Widen the RGB565 endpoints by left shift.
    always_comb
    begin
        r0 = {blocks.endpoint_first[15:11], 3'b000};
        g0 = {blocks.endpoint_first[10:5], 2'b00};
        b0 = {blocks.endpoint_first[4:0], 3'b000};
        r1 = {blocks.endpoint_second[15:11], 3'b000};
        g1 = {blocks.endpoint_second[10:5], 2'b00};
        b1 = {blocks.endpoint_second[4:0], 3'b000};
    end

    // Four-colour palette and queue entry.
    always_comb
    begin
        push_entry.base_x       = base_x;
        push_entry.base_y       = base_y;
        push_entry.mask         = mask;
        push_entry.alpha_bits   = blocks.alpha_bits;
        push_entry.index_bits   = blocks.index_bits;
        push_entry.pal_red[0]   = r0;
        push_entry.pal_red[1]   = r1;
        push_entry.pal_red[2]   = dxt3_pkg::blend(r0, r1);
        push_entry.pal_red[3]   = dxt3_pkg::blend(r1, r0);
        push_entry.pal_green[0] = g0;
        push_entry.pal_green[1] = g1;
        push_entry.pal_green[2] = dxt3_pkg::blend(g0, g1);
        push_entry.pal_green[3] = dxt3_pkg::blend(g1, g0);
        push_entry.pal_blue[0]  = b0;
        push_entry.pal_blue[1]  = b1;
        push_entry.pal_blue[2]  = dxt3_pkg::blend(b0, b1);
        push_entry.pal_blue[3]  = dxt3_pkg::blend(b1, b0);
    end

    // Blocks wholly outside the image are not queued at all.
    assign push = accept && (mask != 16'd0);

    // Raster-order block position.
    always_comb
    begin
        col_inc  = {1'b0, col_reg} + 13'd1;
        row_inc  = {1'b0, row_reg} + 13'd1;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc[dxt3_pkg::PosWidth] || ({col_inc, 2'b00} >= eff_w))
            begin
                col_next = '0;
                if (row_inc[dxt3_pkg::PosWidth] || ({row_inc, 2'b00} >= eff_h))
                    row_next = '0;
                else
                    row_next = row_inc[dxt3_pkg::PosWidth-1:0];
            end
            else
            begin
                col_next = col_inc[dxt3_pkg::PosWidth-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> rtl/core/dxt3_queue.sv
// Two-entry block queue between the front end and the pixel stage.
// Depends on dxt3_pkg.
module dxt3_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  dxt3_pkg::block_entry_t  push_entry,
    input  logic                    pop,
    output dxt3_pkg::block_entry_t  head,
    output dxt3_pkg::queue_status_t status
);

    dxt3_pkg::block_entry_t slot_reg [dxt3_pkg::QueueDepth];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign do_pop        = pop && (count_reg != 2'd0);
    assign head          = slot_reg[rd_ptr_reg];
    assign status.full   = (count_reg == 2'(dxt3_pkg::QueueDepth));
    assign status.empty  = (count_reg == 2'd0);

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> rtl/core/dxt3_back.sv
// Pixel stage: walks the in-image pixels of one block, one per cycle when
// not stalled, into an output register. Depends on dxt3_pkg and dxt3_if.
module dxt3_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dxt3_pkg::block_entry_t  head,
    input  dxt3_pkg::queue_status_t q_status,
    output logic                    pop,
    dxt3_pixel_if.source            pixels
);

    dxt3_pkg::block_entry_t cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    logic [15:0] mask_reg, mask_next;
    logic [3:0]  sel;
    logic [15:0] sel_onehot;
    logic [1:0]  pal_idx;
    logic [3:0]  alpha_nib;
    logic        out_space, emit, last, free;

    logic        out_valid_reg;
    logic [13:0] out_x_reg, out_y_reg;
    logic [7:0]  out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic        out_done_reg;

    // Lowest remaining pixel of the current block.
    always_comb
    begin
        sel = 4'd0;
        for (int i = dxt3_pkg::PixelCount - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                sel = 4'(i);
        end
        sel_onehot = 16'd1 << sel;
    end

    assign out_space = !out_valid_reg || pixels.ready;
    assign emit      = cur_valid_reg && out_space;
    assign last      = emit && ((mask_reg & ~sel_onehot) == 16'd0);
    assign free      = !cur_valid_reg || last;
    assign pop       = free && !q_status.empty;
    assign pal_idx   = cur_reg.index_bits[2*sel +: 2];
    assign alpha_nib = cur_reg.alpha_bits[4*sel +: 4];

    // Current block bookkeeping.
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        mask_next      = mask_reg;
        if (emit)
            mask_next = mask_reg & ~sel_onehot;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            mask_next      = head.mask;
        end
        else if (last)
        begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pixels.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        if (pop)
            cur_reg <= head;
        if (emit)
        begin
            out_x_reg    <= cur_reg.base_x + {12'd0, sel[1:0]};
            out_y_reg    <= cur_reg.base_y + {12'd0, sel[3:2]};
            out_r_reg    <= cur_reg.pal_red[pal_idx];
            out_g_reg    <= cur_reg.pal_green[pal_idx];
            out_b_reg    <= cur_reg.pal_blue[pal_idx];
            out_a_reg    <= {alpha_nib, alpha_nib};
            out_done_reg <= last;
        end
    end

    assign pixels.valid      = out_valid_reg;
    assign pixels.pixel_x    = out_x_reg;
    assign pixels.pixel_y    = out_y_reg;
    assign pixels.red        = out_r_reg;
    assign pixels.green      = out_g_reg;
    assign pixels.blue       = out_b_reg;
    assign pixels.alpha      = out_a_reg;
    assign pixels.block_done = out_done_reg;

endmodule
